// File: rtl/pfe_pkg.sv
`default_nettype none
package pfe_pkg;

    localparam int unsigned SQ_DIM  = 5;
    localparam int unsigned CODE_W  = 5;
    localparam int unsigned POS_W   = 3;
    localparam int unsigned ROW_W   = SQ_DIM * CODE_W;
    localparam int unsigned CFG_A_W = 3;

    localparam logic [CFG_A_W-1:0] REG_KEY_ROW_0    = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_KEY_ROW_LAST = 3'd4;

    localparam logic [POS_W-1:0] POS_LAST = 3'd4;

    typedef logic [CODE_W-1:0] t_code;
    // one row: column 0 in the lowest bits
    typedef logic [SQ_DIM-1:0][CODE_W-1:0] t_row;
    typedef t_row [SQ_DIM-1:0] t_square;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
    } t_pos;

    function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
        return (p == POS_LAST) ? '0 : p + POS_W'(1);
    endfunction

endpackage
`default_nettype wire

// File: rtl/playfair_digram_encrypt.sv
`default_nettype none
// channel     dir  handshake                 payload
// s_axis      in   tvalid/tready             tdata[4:0] letter
// m_axis      out  tvalid/tready             tdata[4:0] cipher_first, [9:5] cipher_second
//                                            tuser[0] not_in_key
// cfg         in   i_cfg_we (no wait)        i_cfg_addr row index, i_cfg_data row
//
// One letter per cycle while o_s_axis_tready is high. A pair is latched in the
// pair stage when its second letter arrives, then the square lookup and cipher
// rules run combinationally into the result register. Lookup is 25 parallel compares.
// Reset clears the square to all-zero codes, the held letter and both valid flags.
// A stall on m_axis fills the pair stage, then drops o_s_axis_tready.
module playfair_digram_encrypt (
    input  wire         i_clk,
    input  wire         i_rst_n,

    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [4:0] letter

    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [4:0] cipher_first, [9:5] cipher_second
    output logic [0:0]  o_m_axis_tuser,   // [0] not_in_key

    input  wire                          i_cfg_we,
    input  wire  [pfe_pkg::CFG_A_W-1:0]  i_cfg_addr,
    input  wire  [pfe_pkg::ROW_W-1:0]    i_cfg_data
);

    pfe_pkg::t_square r_square;

    logic           r_pending;
    pfe_pkg::t_code r_held;

    logic           r_pair_valid;
    pfe_pkg::t_code r_pair_a;
    pfe_pkg::t_code r_pair_b;

    logic           r_out_valid;
    pfe_pkg::t_code r_out_first;
    pfe_pkg::t_code r_out_second;
    logic           r_out_miss;

    pfe_pkg::t_code n_first;
    pfe_pkg::t_code n_second;
    logic           n_miss;

    pfe_pkg::t_pos  pos_a;
    pfe_pkg::t_pos  pos_b;
    pfe_pkg::t_code in_code;

    logic s_accept;
    logic out_adv;
    logic pair_adv;

    assign in_code  = i_s_axis_tdata[pfe_pkg::CODE_W-1:0];
    assign out_adv  = !r_out_valid || i_m_axis_tready;
    assign pair_adv = !r_pair_valid || out_adv;
    assign o_s_axis_tready = pair_adv;
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square <= '0;
        end else if (i_cfg_we && i_cfg_addr <= pfe_pkg::REG_KEY_ROW_LAST) begin
            r_square[i_cfg_addr] <= i_cfg_data;
        end
    end

    // pair stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= 1'b0;
            r_held       <= '0;
            r_pair_valid <= 1'b0;
        end else begin
            if (pair_adv) begin
                r_pair_valid <= s_accept && r_pending;
            end
            if (s_accept) begin
                r_pending <= !r_pending;
                if (!r_pending) begin
                    r_held <= in_code;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && r_pending) begin
            r_pair_a <= r_held;
            r_pair_b <= in_code;
        end
    end

    pfe_lookup u_lookup_a (
        .i_square (r_square),
        .i_code   (r_pair_a),
        .o_pos    (pos_a)
    );

    pfe_lookup u_lookup_b (
        .i_square (r_square),
        .i_code   (r_pair_b),
        .o_pos    (pos_b)
    );

    always_comb begin
        n_first  = '0;
        n_second = '0;
        n_miss   = !(pos_a.found && pos_b.found);
        if (!n_miss) begin
            priority if (pos_a.row == pos_b.row) begin
                n_first  = r_square[pos_a.row][pfe_pkg::next_pos(pos_a.col)];
                n_second = r_square[pos_b.row][pfe_pkg::next_pos(pos_b.col)];
            end else if (pos_a.col == pos_b.col) begin
                n_first  = r_square[pfe_pkg::next_pos(pos_a.row)][pos_a.col];
                n_second = r_square[pfe_pkg::next_pos(pos_b.row)][pos_b.col];
            end else begin
                n_first  = r_square[pos_a.row][pos_b.col];
                n_second = r_square[pos_b.row][pos_a.col];
            end
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_pair_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_pair_valid) begin
            r_out_first  <= n_first;
            r_out_second <= n_second;
            r_out_miss   <= n_miss;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_second, r_out_first};
    assign o_m_axis_tuser  = r_out_miss;

    a_first_letter_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && !r_pending |=> r_pending && !r_pair_valid)
        else $error("first letter did not open a pair");

    a_second_letter_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && r_pending |=> r_pair_valid && !r_pending)
        else $error("second letter did not complete a pair");

    a_pair_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pair_valid && out_adv |=> r_out_valid)
        else $error("pair lost on way to result");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_miss |-> r_out_first == '0 && r_out_second == '0)
        else $error("missing letter gave nonzero cipher");

endmodule
`default_nettype wire

// File: rtl/pfe_lookup.sv
`default_nettype none
module pfe_lookup (
    input  wire pfe_pkg::t_square i_square,
    input  wire pfe_pkg::t_code   i_code,
    output pfe_pkg::t_pos         o_pos
);

    // last match in row-major order wins
    always_comb begin
        o_pos = '0;
        for (int r = 0; r < int'(pfe_pkg::SQ_DIM); r++) begin
            for (int c = 0; c < int'(pfe_pkg::SQ_DIM); c++) begin
                if (i_square[r][c] == i_code) begin
                    o_pos.found = 1'b1;
                    o_pos.row   = pfe_pkg::POS_W'(r);
                    o_pos.col   = pfe_pkg::POS_W'(c);
                end
            end
        end
    end

endmodule
`default_nettype wire
